// ===== hw/rtl/linear_hash_bucket_page_locator_unit_macros.svh =====
// Assertion macros for the bucket and page locator.
`ifndef LINEAR_HASH_BUCKET_PAGE_LOCATOR_UNIT_MACROS_SVH
`define LINEAR_HASH_BUCKET_PAGE_LOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LHBPL_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("locator check failed");

// Next-cycle implication, checked outside reset.
`define LHBPL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("locator check failed");

`endif

// ===== hw/rtl/lhbpl_pkg.sv =====
// Types and constants shared by the bucket and page locator.
`default_nettype none
package lhbpl_pkg;

    localparam int unsigned SPARE_ENTRIES = 32;
    localparam int unsigned SPARE_AW      = $clog2(SPARE_ENTRIES);
    localparam int unsigned LEN_W         = 6;
    localparam logic [31:0] FNV_PRIME     = 32'd16777619;

    // Input item kinds carried on tuser
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_LOAD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HIGH_MASK  = 2'd0;
    localparam logic [1:0] CFG_LOW_MASK   = 2'd1;
    localparam logic [1:0] CFG_MAX_BUCKET = 2'd2;
    localparam logic [1:0] CFG_LAST_PAGE  = 2'd3;

    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 64;

endpackage
`default_nettype wire

// ===== hw/rtl/linear_hash_bucket_page_locator_unit.sv =====
// Linear-hashing bucket and page locator: FNV-0 key hash, bucket masking, spare page lookup.
//
// Input stream (s): one item per transfer. tuser is the kind: key byte, key end
// without a byte, or spare table load. tlast marks the final key byte. A final
// byte or a key end yields one result; other items yield none.
// Output stream (m): bucket number and page number on tdata, page range flag on tuser.
// Configuration: plain write port, index 0 high mask, 1 low mask, 2 max bucket,
// 3 last page; write only while no key end is in flight.
// Throughput: one item per cycle while the output accepts. The hash multiply sits in
// the accept cycle; the bucket masking and bit length feed the spare RAM read port from
// the first stage register, and the page add and range compare work on the second stage
// register and the RAM read data, ahead of the output register.
// Reset clears the running hash, the configuration registers, pipeline valids and the spare
// valid bits; an entry never loaded since reset reads as zero. No clearing pass.
// Stall: each stage holds while the one ahead is full and held; the input stays
// ready while any stage is empty or the output is taken.
`default_nettype none
`include "linear_hash_bucket_page_locator_unit_macros.svh"
module linear_hash_bucket_page_locator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // key_byte [7:0], spare_index [12:8], spare_value [44:13], zero fill [47:45]
    input  wire logic [lhbpl_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // kind [1:0]
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // bucket_number [31:0], page_number [63:32]
    output logic [lhbpl_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // page_in_range [0]
    output logic             o_m_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam int unsigned AW = lhbpl_pkg::SPARE_AW;

    logic [31:0] r_high_mask, r_low_mask, r_max_bucket, r_last_page;
    logic [31:0] r_hash, n_hash;
    logic [lhbpl_pkg::SPARE_ENTRIES-1:0] r_spare_vld;

    logic        r_s1_v;
    logic [31:0] r_s1_hash;
    logic        r_s2_v;
    logic [31:0] r_s2_bucket;
    logic        r_s2_use;
    logic        r_out_v;
    logic [31:0] r_out_bucket, r_out_page;
    logic        r_out_inr;

    logic        w_en1, w_en2, w_en3;
    logic        w_accept, w_finish;
    logic [7:0]  w_key_byte;
    logic [4:0]  w_spare_idx;
    logic [31:0] w_spare_val;
    logic        w_load;
    logic [31:0] w_hash_step, w_fin_hash;
    logic [31:0] w_bkt_hi, w_bucket;
    logic [lhbpl_pkg::LEN_W-1:0] w_len;
    logic        w_len_ok;
    logic [31:0] w_ram_rdata, w_spare, w_page;

    assign w_key_byte  = i_s_tdata[7:0];
    assign w_spare_idx = i_s_tdata[12:8];
    assign w_spare_val = i_s_tdata[44:13];

    // Stage enables: a stage advances when empty or when the one ahead moves
    assign w_en3      = !r_out_v || i_m_tready;
    assign w_en2      = !r_s2_v || w_en3;
    assign w_en1      = !r_s1_v || w_en2;
    assign o_s_tready = w_en1;
    assign w_accept   = i_s_tvalid && w_en1;

    assign w_hash_step = (r_hash * lhbpl_pkg::FNV_PRIME) ^ {24'd0, w_key_byte};
    assign w_load = w_accept && (i_s_tuser == lhbpl_pkg::KIND_LOAD)
                    && ({1'b0, w_spare_idx} < 6'(lhbpl_pkg::SPARE_ENTRIES));

    always_comb begin
        n_hash     = r_hash;
        w_finish   = 1'b0;
        w_fin_hash = r_hash;
        case (i_s_tuser)
            lhbpl_pkg::KIND_BYTE: begin
                if (i_s_tlast) begin
                    w_finish   = 1'b1;
                    w_fin_hash = w_hash_step;
                    n_hash     = '0;
                end else begin
                    n_hash = w_hash_step;
                end
            end
            lhbpl_pkg::KIND_END: begin
                w_finish = 1'b1;
                n_hash   = '0;
            end
            default: begin
                n_hash = r_hash;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_mask  <= '0;
            r_low_mask   <= '0;
            r_max_bucket <= '0;
            r_last_page  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lhbpl_pkg::CFG_HIGH_MASK:  r_high_mask  <= i_cfg_wdata;
                lhbpl_pkg::CFG_LOW_MASK:   r_low_mask   <= i_cfg_wdata;
                lhbpl_pkg::CFG_MAX_BUCKET: r_max_bucket <= i_cfg_wdata;
                lhbpl_pkg::CFG_LAST_PAGE:  r_last_page  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Running hash and spare valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_spare_vld <= '0;
        end else begin
            if (w_accept) begin
                r_hash <= n_hash;
            end
            if (w_load) begin
                r_spare_vld[w_spare_idx[AW-1:0]] <= 1'b1;
            end
        end
    end

    // Stage 1: bucket masking and bit length, spare RAM address
    assign w_bkt_hi = r_s1_hash & r_high_mask;
    assign w_bucket = (w_bkt_hi > r_max_bucket) ? (w_bkt_hi & r_low_mask) : w_bkt_hi;

    always_comb begin
        w_len = '0;
        for (int i = 0; i < 32; i++) begin
            if (w_bucket[i]) begin
                w_len = lhbpl_pkg::LEN_W'(i + 1);
            end
        end
    end

    assign w_len_ok = w_len < lhbpl_pkg::LEN_W'(lhbpl_pkg::SPARE_ENTRIES);

    lhbpl_ram #(
        .WIDTH (32),
        .DEPTH (lhbpl_pkg::SPARE_ENTRIES)
    ) u_spare_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (w_spare_idx[AW-1:0]),
        .i_wdata (w_spare_val),
        .i_re    (w_en2 && r_s1_v),
        .i_raddr (w_len[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Stage 2: page add and range check
    assign w_spare = r_s2_use ? w_ram_rdata : '0;
    assign w_page  = r_s2_bucket + w_spare;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en1) begin
                r_s1_v <= w_accept && w_finish;
            end
            if (w_en2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_en3) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_hash <= w_fin_hash;
        end
        if (w_en2) begin
            r_s2_bucket <= w_bucket;
            // old valid bit on a same-cycle load: the load is younger
            r_s2_use    <= w_len_ok && r_spare_vld[w_len[AW-1:0]];
        end
        if (w_en3) begin
            r_out_bucket <= r_s2_bucket;
            r_out_page   <= w_page;
            r_out_inr    <= (w_page != '0) && (w_page <= r_last_page);
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {r_out_page, r_out_bucket};
    assign o_m_tuser  = r_out_inr;

    `LHBPL_ASSERT_SAME(a_s1_interlock, i_clk, i_rst_n, r_s1_v && !w_en2, !o_s_tready)
    `LHBPL_ASSERT_NEXT(a_hash_clear, i_clk, i_rst_n, w_accept && w_finish, r_hash == '0)
    `LHBPL_ASSERT_NEXT(a_s2_hold, i_clk, i_rst_n, r_out_v && !i_m_tready && r_s2_v, r_s2_v)

endmodule
`default_nettype wire

// ===== hw/rtl/lhbpl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lhbpl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the old word on a same-address write
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the linear-hashing bucket and page locator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_NONE   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         ITEM_TARGET = 1700;

    typedef struct packed {
        logic [31:0] bucket;
        logic [31:0] page;
        logic        in_range;
    } t_locate;

    // Shadow of the locator: registers, running hash, spare table and pending locations
    class t_locator_sb;
        logic [31:0] high_mask, low_mask, max_bucket, last_page;
        logic [31:0] run_hash;
        logic [31:0] spares [lhbpl_pkg::SPARE_ENTRIES];
        t_locate     expected_q [$];
        int          errors;

        function new();
            high_mask  = '0;
            low_mask   = '0;
            max_bucket = '0;
            last_page  = '0;
            run_hash   = '0;
            errors     = 0;
            foreach (spares[i]) spares[i] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                lhbpl_pkg::CFG_HIGH_MASK:  high_mask  = val;
                lhbpl_pkg::CFG_LOW_MASK:   low_mask   = val;
                lhbpl_pkg::CFG_MAX_BUCKET: max_bucket = val;
                lhbpl_pkg::CFG_LAST_PAGE:  last_page  = val;
                default: ;
            endcase
        endfunction

        function int bit_len(logic [31:0] v);
            for (int b = 31; b >= 0; b--)
                if (v[b]) return b + 1;
            return 0;
        endfunction

        function void close_key();
            t_locate     loc;
            logic [31:0] spare;
            int          len;
            loc.bucket = run_hash & high_mask;
            if (loc.bucket > max_bucket) loc.bucket = loc.bucket & low_mask;
            len   = bit_len(loc.bucket);
            spare = (len < lhbpl_pkg::SPARE_ENTRIES) ? spares[len] : 32'd0;
            loc.page     = loc.bucket + spare;
            loc.in_range = (loc.page != 0) && (loc.page <= last_page);
            expected_q.push_back(loc);
            run_hash = '0;
        endfunction

        function void note_input(logic [1:0] kind, logic [7:0] key_b, logic last,
                                 logic [4:0] sidx, logic [31:0] sval);
            case (kind)
                lhbpl_pkg::KIND_BYTE: begin
                    run_hash = (run_hash * lhbpl_pkg::FNV_PRIME) ^ {24'd0, key_b};
                    if (last) close_key();
                end
                lhbpl_pkg::KIND_END: close_key();
                lhbpl_pkg::KIND_LOAD: begin
                    if (sidx < lhbpl_pkg::SPARE_ENTRIES) spares[sidx] = sval;
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("tb: mismatch on %s: got %h, expected %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [63:0] data, logic flag);
            t_locate want;
            if (expected_q.size() == 0) begin
                report("unexpected result bucket", data[31:0], 32'd0);
                return;
            end
            want = expected_q.pop_front();
            if (data[31:0] !== want.bucket) report("bucket_number", data[31:0], want.bucket);
            if (data[63:32] !== want.page) report("page_number", data[63:32], want.page);
            if (flag !== want.in_range)
                report("page_in_range", {31'd0, flag}, {31'd0, want.in_range});
        endtask
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [lhbpl_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    logic [1:0]                        i_s_tuser;
    logic                              i_s_tlast;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [lhbpl_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                              o_m_tuser;
    logic                              i_cfg_we;
    logic [1:0]                        i_cfg_addr;
    logic [31:0]                       i_cfg_wdata;

    t_locator_sb sb;
    bit          idle_on;
    bit          hold_req;
    int          items_sent;

    linear_hash_bucket_page_locator_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Check every result transfer against the oldest pending location
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1)
            sb.check_result(o_m_tdata, o_m_tuser);
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    task send_item(logic [1:0] kind, logic [7:0] key_b, logic last,
                   logic [4:0] sidx, logic [31:0] sval);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'd0, sval, sidx, key_b};
        i_s_tuser  <= kind;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        sb.note_input(kind, key_b, last, sidx, sval);
        if (kind != KIND_NONE) items_sent++;
    endtask

    task send_byte(logic [7:0] key_b, logic last);
        send_item(lhbpl_pkg::KIND_BYTE, key_b, last, 5'($urandom), $urandom);
    endtask

    task send_end();
        send_item(lhbpl_pkg::KIND_END, 8'($urandom), 1'($urandom), 5'($urandom), $urandom);
    endtask

    task send_load(logic [4:0] sidx, logic [31:0] sval);
        send_item(lhbpl_pkg::KIND_LOAD, 8'($urandom), 1'($urandom), sidx, sval);
    endtask

    task send_noise();
        send_item(KIND_NONE, 8'($urandom), 1'($urandom), 5'($urandom), $urandom);
    endtask

    function logic [31:0] pick_spare();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(0, 4096);
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Stop offering, wait for every pending location, then let the pipeline empty
    task drain();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task configure(logic [31:0] hm, logic [31:0] lm, logic [31:0] mb, logic [31:0] lp);
        logic [31:0] vals [4];
        vals = '{hm, lm, mb, lp};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= 2'(r);
            i_cfg_wdata <= vals[r];
            @(posedge i_clk);
            sb.set_reg(2'(r), vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Masks as a growing linear-hash table would hold them at split level n
    task configure_level(int n);
        logic [32:0] hm;
        logic [31:0] lm, mb, lp;
        hm = (33'd1 << (n + 1)) - 33'd1;
        lm = (32'd1 << n) - 32'd1;
        mb = lm + 32'd1 + $urandom_range(0, lm);
        case ($urandom_range(0, 3))
            0:       lp = pick_word();
            default: lp = mb + $urandom_range(0, 4096);
        endcase
        configure(hm[31:0], lm, mb, lp);
    endtask

    task random_key();
        int nbytes;
        bit close_by_end;
        nbytes       = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        close_by_end = (nbytes == 0) || ($urandom_range(0, 4) == 0);
        for (int k = 0; k < nbytes; k++) begin
            if ($urandom_range(0, 9) == 0) send_load(5'($urandom), pick_spare());
            if ($urandom_range(0, 29) == 0) send_noise();
            send_byte(8'($urandom), (k == nbytes - 1) && !close_by_end);
        end
        if (close_by_end) send_end();
    endtask

    initial begin
        int phase_start;
        int settle;
        sb          = new();
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        items_sent  = 0;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= lhbpl_pkg::KIND_BYTE;
        i_s_tlast   <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= lhbpl_pkg::CFG_HIGH_MASK;
        i_cfg_wdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers and spare table at their reset values
        send_byte(8'h00, 1'b1);
        send_end();
        drain();

        // Everything open: bucket is the raw hash, spare adds may wrap
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_load(5'd0, 32'd7);
        send_load(5'd31, 32'hFFFF_FFFF);
        send_load(5'd8, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1);
        send_end();
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_item(lhbpl_pkg::KIND_END, 8'h5A, 1'b1, 5'd3, 32'h0);
        send_item(lhbpl_pkg::KIND_LOAD, 8'hFF, 1'b1, 5'd1, 32'h1);
        send_item(KIND_NONE, 8'hAA, 1'b1, 5'd31, 32'hFFFF_FFFF);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h7E, 1'b1);
        drain();

        // Everything closed: bucket 0, page from spare entry 0, never in range
        configure(32'd0, 32'd0, 32'd0, 32'd0);
        send_byte(8'hFF, 1'b1);
        drain();

        // Range boundary on page 7
        configure(32'd0, 32'd0, 32'd0, 32'd7);
        send_end();
        drain();
        configure(32'd0, 32'd0, 32'd0, 32'd6);
        send_end();
        drain();

        // Deepest and shallowest split levels
        configure_level(31);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b1);
        drain();
        configure_level(0);
        send_byte(8'h33, 1'b1);
        send_end();
        drain();

        for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
            case ($urandom_range(0, 3))
                0: configure(pick_word(), pick_word(), pick_word(), pick_word());
                default: configure_level($urandom_range(0, 31));
            endcase
            idle_on = (items_sent < ITEM_TARGET - 250) && ($urandom_range(0, 3) != 0);
            if (phase == 1) begin
                // Hold the output back while key ends keep coming: fill and stall the pipe
                hold_req = 1'b1;
                repeat (40) send_end();
            end
            phase_start = items_sent;
            while (items_sent - phase_start < 140 && items_sent < ITEM_TARGET)
                random_key();
            drain();
        end

        idle_on = 1'b0;
        i_s_tvalid <= 1'b0;
        for (settle = 0; sb.pending() != 0 && settle < 2000; settle++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) sb.report("locations never delivered", sb.pending(), 32'd0);
        if (sb.errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lhbpl_pkg.sv
hw/rtl/lhbpl_ram.sv
hw/rtl/linear_hash_bucket_page_locator_unit.sv
test/tb.sv
